### sv/frame_dim_dedup_rate_gate_macros.svh
// assertion macros for the frame dimmer / repeat suppressor
// used by the top level only, no other dependencies
`ifndef FRAME_DIM_DEDUP_RATE_GATE_MACROS_SVH
`define FRAME_DIM_DEDUP_RATE_GATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FDG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fdg_pkg.sv
// shared types, codes and constants of the frame dimmer / repeat suppressor
// no dependencies
`default_nettype none

package fdg_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 16384;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned IDX_W     = 15;
  localparam int unsigned CAP_W     = 15;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned BRIGHT_W  = 9;
  localparam int unsigned PROD_W    = PIX_W + BRIGHT_W;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0]    IDX_MAX     = '1;
  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = BRIGHT_W'(256);  // 1.0 in q1.8
  localparam logic [PROD_W-1:0]   ROUND_HALF  = PROD_W'(128);    // 0.5 lsb for rounding

  // func codes of an input item
  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_EMPTY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // frame status codes
  localparam logic [1:0] STATUS_PROGRESS   = 2'd0;
  localparam logic [1:0] STATUS_SEND       = 2'd1;
  localparam logic [1:0] STATUS_SUPPRESSED = 2'd2;
  localparam logic [1:0] STATUS_REJECTED   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_EMPTY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [PIX_W-1:0] pixel;
    logic             last_byte;
    logic [TIME_W-1:0] now_ms;
    logic             force_req;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] scaled_pixel;
    logic             end_of_frame;
    logic [1:0]       frame_status;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t               op;
    logic [PIX_W-1:0]  scaled;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              last;
    logic [TIME_W-1:0] now_ms;
    logic              force_req;
  } job_t;

  typedef struct packed {
    logic                output_enabled;
    logic [CAP_W-1:0]    frame_capacity;
    logic [BRIGHT_W-1:0] brightness_q8;
    logic [TIME_W-1:0]   resend_interval;
    logic                hist_clear;
  } cfg_t;

endpackage

`default_nettype wire

### sv/frame_dim_dedup_rate_gate.sv
// Frame dimmer with repeat suppression and send-rate gate. A display frame
// streams in one byte per request; each byte is scaled by brightness_q8
// (q1.8, 256 = full, larger values act as full) with round-to-nearest and
// comes back as one result per request. Scaled bytes land in the working
// half of a two-bank frame store and are compared with the reference half,
// which holds the frame last sent. The result that ends a frame (last_byte
// set, or an empty-frame request) carries send, suppressed or rejected.
// Throughput is one request per clock while result_stall is low: the front end
// classifies and scales in the accept cycle, a two-entry queue decouples it
// from the back end, and the back end reads both banks into its read stage,
// then compares, writes and decides from there into the output register.
// While a finished result waits on result_stall the read stage and the queue
// still take three more requests, then item_stall rises. The frame store has
// no clearing pass; entries are only compared after the sent frame wrote them.
// Configuration is written only while the block is idle, a rule the user must
// keep and the block does not enforce; a capacity write whose low CAP_W bits
// exceed FRAME_BYTES is dropped, an accepted one clears the send history.
// depends on fdg_pkg, fdg_front, fdg_queue, fdg_back, fdg_ram and the macros header
`default_nettype none

`include "frame_dim_dedup_rate_gate_macros.svh"

module frame_dim_dedup_rate_gate
  import fdg_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 item_valid,
  output      logic                 item_stall,
  input  wire in_t                  item,
  // result channel
  output      logic                 result_valid,
  input  wire logic                 result_stall,
  output      out_t                 result,
  // register writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic                output_enabled;
  logic [CAP_W-1:0]    frame_capacity;
  logic [BRIGHT_W-1:0] brightness_q8;
  logic [TIME_W-1:0]   resend_interval;
  logic                cap_write_ok;
  cfg_t                cfg;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  logic q_valid;
  job_t q_job;
  logic pop;

  // terms of the checks below
  logic mid_res;
  logic mid_ok;
  logic acc_in;
  logic off_eof;
  logic off_ok;

  // capacity whose low CAP_W bits exceed the store size is ignored entirely
  assign cap_write_ok = cfg_we && (cfg_index == REG_CAPACITY) &&
                        (cfg_wdata[CAP_W-1:0] <= CAP_W'(FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enabled  <= 1'b0;
      frame_capacity  <= '0;
      brightness_q8   <= BRIGHT_FULL;
      resend_interval <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:   output_enabled  <= cfg_wdata[0];
        REG_CAPACITY: begin
          if (cap_write_ok) begin
            frame_capacity <= cfg_wdata[CAP_W-1:0];
          end
        end
        REG_BRIGHT:   brightness_q8   <= cfg_wdata[BRIGHT_W-1:0];
        REG_INTERVAL: resend_interval <= cfg_wdata[TIME_W-1:0];
      endcase
    end
  end

  always_comb begin
    cfg.output_enabled  = output_enabled;
    cfg.frame_capacity  = frame_capacity;
    cfg.brightness_q8   = brightness_q8;
    cfg.resend_interval = resend_interval;
    cfg.hist_clear      = cap_write_ok;   // send history dropped with new capacity
  end

  // accept, scale and track position in frame
  fdg_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .q_full     (q_full),
    .item_stall (item_stall),
    .push       (push),
    .job        (push_job)
  );

  // decoupling queue
  fdg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // store compare, send decision and result register
  fdg_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign mid_res = result_valid && !result.end_of_frame;
  assign mid_ok  = (result.frame_status == STATUS_PROGRESS);
  assign acc_in  = item_valid && !item_stall;
  assign off_eof = result_valid && result.end_of_frame && !output_enabled;
  assign off_ok  = (result.frame_status == STATUS_REJECTED);

  // a status other than in-progress only on the frame-ending result
  `FDG_ASSERT_NOW(a_status_only_at_eof, clk, rst, mid_res, mid_ok, "status on mid-frame result")

  // every accepted request is held in the queue on the next cycle
  `FDG_ASSERT_NEXT(a_accept_reaches_queue, clk, rst, acc_in, q_valid, "accepted request lost")

  // with the block disabled every frame end is rejected
  `FDG_ASSERT_NOW(a_disabled_rejects, clk, rst, off_eof, off_ok, "disabled block sent a frame")

endmodule

`default_nettype wire

### sv/fdg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module fdg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/fdg_front.sv
// front end: accepts requests, scales bytes, tracks frame position
// depends on fdg_pkg
`default_nettype none

module fdg_front
  import fdg_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic item_valid,
  input  wire in_t  item,
  input  wire logic q_full,
  output      logic item_stall,
  output      logic push,
  output      job_t job
);

  logic [IDX_W-1:0]    byte_index;
  logic [IDX_W-1:0]    byte_index_next;
  logic [BRIGHT_W-1:0] bright;
  logic [PROD_W-1:0]   rounded;
  op_t                 op;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    unique case (item.func)
      FUNC_BYTE:   op = OP_BYTE;
      FUNC_EMPTY:  op = OP_EMPTY;
      FUNC_CLEAR:  op = OP_CLEAR;
      FUNC_UNUSED: op = OP_NOP;
    endcase
  end

  // clamp above full scale, then round to nearest
  assign bright  = (cfg.brightness_q8 > BRIGHT_FULL) ? BRIGHT_FULL : cfg.brightness_q8;
  assign rounded = PROD_W'(item.pixel) * PROD_W'(bright) + ROUND_HALF;

  always_comb begin
    job.op        = op;
    job.scaled    = rounded[PIX_W +: PIX_W];
    job.idx       = byte_index;
    job.in_range  = (byte_index < cfg.frame_capacity) &&
                    (byte_index < IDX_W'(FRAME_BYTES));
    job.last      = item.last_byte;
    job.now_ms    = item.now_ms;
    job.force_req = item.force_req;
  end

  always_comb begin
    byte_index_next = byte_index;
    unique case (op)
      OP_BYTE: begin
        if (item.last_byte) begin
          byte_index_next = '0;
        end else if (byte_index < IDX_MAX) begin
          byte_index_next = byte_index + IDX_W'(1);
        end
      end
      OP_EMPTY, OP_CLEAR: byte_index_next = '0;
      OP_NOP:             byte_index_next = byte_index;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (push) begin
      byte_index <= byte_index_next;
    end
  end

endmodule

`default_nettype wire

### sv/fdg_queue.sv
// short request queue between front and back
// depends on fdg_pkg
`default_nettype none

module fdg_queue
  import fdg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output      logic full,
  output      logic q_valid,
  output      job_t q_job
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/fdg_back.sv
// back end: frame store read/compare/write, send decision, result register
// depends on fdg_pkg and fdg_ram
`default_nettype none

module fdg_back
  import fdg_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output      logic pop,
  output      logic result_valid,
  input  wire logic result_stall,
  output      out_t result
);

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  // read stage
  logic r_valid;
  job_t r_job;

  // execute
  logic exec;

  // history and frame progress
  logic              ref_bank;
  logic [CAP_W-1:0]  stored_size;
  logic              differs;
  logic              oversize;
  logic [TIME_W-1:0] last_send_time;
  logic              has_sent;

  // store ports
  logic [PIX_W-1:0] rdata [2];
  logic             wr_en;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;

  // bypass for a read issued on the edge of a write to the same entry
  logic             fwd_hit;
  logic             fwd_bank;
  logic [PIX_W-1:0] fwd_data;

  logic [PIX_W-1:0]  ref_byte;
  logic              cur_diff;
  logic              cur_over;
  logic              finish;
  logic              fin_diff;
  logic              fin_over;
  logic [SIZE_W-1:0] size;
  logic [TIME_W-1:0] since_last;
  logic              rejected;
  logic              changed;
  logic              elapsed;
  logic              send;
  out_t              res_next;

  assign exec = r_valid && (!result_valid || !result_stall);
  assign pop  = q_valid && (!r_valid || exec);

  assign raddr = q_job.idx[AW-1:0];
  assign waddr = r_job.idx[AW-1:0];
  assign wr_en = exec && (r_job.op == OP_BYTE) && r_job.in_range;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    fdg_ram #(
      .WIDTH (PIX_W),
      .DEPTH (FRAME_BYTES)
    ) u_bank (
      .clk   (clk),
      .we    (wr_en && (ref_bank != 1'(b))),
      .waddr (waddr),
      .wdata (r_job.scaled),
      .re    (pop),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_hit  <= wr_en && (waddr == raddr);
      fwd_bank <= !ref_bank;
      fwd_data <= r_job.scaled;
    end
  end

  always_comb begin
    if (fwd_hit && (fwd_bank == ref_bank)) begin
      ref_byte = fwd_data;
    end else begin
      ref_byte = ref_bank ? rdata[1] : rdata[0];
    end
  end

  always_comb begin
    cur_diff = (r_job.op == OP_BYTE) && r_job.in_range &&
               ((r_job.idx >= stored_size) || (ref_byte != r_job.scaled));
    cur_over = (r_job.op == OP_BYTE) && !r_job.in_range;
    finish   = ((r_job.op == OP_BYTE) && r_job.last) || (r_job.op == OP_EMPTY);
    fin_diff = (r_job.op == OP_BYTE) && (differs || cur_diff);
    fin_over = (r_job.op == OP_BYTE) && (oversize || cur_over);
    size     = (r_job.op == OP_BYTE) ? SIZE_W'(r_job.idx) + SIZE_W'(1) : '0;

    since_last = r_job.now_ms - last_send_time;
    rejected   = !cfg.output_enabled || fin_over ||
                 (size > SIZE_W'(cfg.frame_capacity));
    changed    = !has_sent || (size != SIZE_W'(stored_size)) || fin_diff;
    elapsed    = has_sent && (since_last >= cfg.resend_interval);
    send       = !rejected && (r_job.force_req || changed || elapsed);

    res_next.scaled_pixel = (r_job.op == OP_BYTE) ? r_job.scaled : '0;
    res_next.end_of_frame = finish;
    if (!finish) begin
      res_next.frame_status = STATUS_PROGRESS;
    end else if (rejected) begin
      res_next.frame_status = STATUS_REJECTED;
    end else if (send) begin
      res_next.frame_status = STATUS_SEND;
    end else begin
      res_next.frame_status = STATUS_SUPPRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid <= 1'b1;
    end else if (exec) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_bank       <= 1'b0;
      stored_size    <= '0;
      differs        <= 1'b0;
      oversize       <= 1'b0;
      last_send_time <= '0;
      has_sent       <= 1'b0;
    end else begin
      if (exec) begin
        unique case (r_job.op)
          OP_BYTE, OP_EMPTY: begin
            if (finish) begin
              differs  <= 1'b0;
              oversize <= 1'b0;
              if (send) begin
                ref_bank       <= !ref_bank;
                stored_size    <= size[CAP_W-1:0];
                last_send_time <= r_job.now_ms;
                has_sent       <= 1'b1;
              end
            end else begin
              differs  <= differs || cur_diff;
              oversize <= oversize || cur_over;
            end
          end
          OP_CLEAR: begin
            differs        <= 1'b0;
            oversize       <= 1'b0;
            stored_size    <= '0;
            last_send_time <= '0;
            has_sent       <= 1'b0;
          end
          OP_NOP: begin
            differs <= differs;
          end
        endcase
      end
      if (cfg.hist_clear) begin
        stored_size    <= '0;
        last_send_time <= '0;
        has_sent       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
